// ----- hw/rtl/swlc_pkg.sv -----
package swlc_pkg;

  localparam int unsigned SampleW = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned TensW   = 3;
  localparam int unsigned DigitW  = 4;

  // digit limits at which a count carries
  localparam logic [DigitW:0] TenthsLimit = 5'd10;
  localparam logic [DigitW:0] OnesLimit   = 5'd10;
  localparam logic [TensW:0]  TensLimit   = 4'd6;

  // window reset values
  localparam logic [SampleW-1:0] StartLowRst  = 8'd50;
  localparam logic [SampleW-1:0] StartHighRst = 8'd60;
  localparam logic [SampleW-1:0] LapLowRst    = 8'd100;
  localparam logic [SampleW-1:0] LapHighRst   = 8'd110;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    MODE_STOPPED = 2'd0,
    MODE_RUNNING = 2'd1,
    MODE_LAPPED  = 2'd2
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_START_LOW  = 3'd0,
    REG_START_HIGH = 3'd1,
    REG_LAP_LOW    = 3'd2,
    REG_LAP_HIGH   = 3'd3
  } cfg_reg_e;

  // button decode of one converter reading
  typedef struct packed {
    logic start;
    logic lap;
  } press_t;

  // displayed time and mode after an item
  typedef struct packed {
    logic [TensW-1:0]  tens;
    logic [DigitW-1:0] ones;
    logic [DigitW-1:0] tenths;
    mode_e             mode;
  } shown_t;

endpackage

// ----- hw/rtl/swlc_classify.sv -----
module swlc_classify (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [swlc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [swlc_pkg::SampleW-1:0]   cfg_data_i,
  input  logic [swlc_pkg::SampleW-1:0]   sample_i,
  output swlc_pkg::press_t               press_o
);
  import swlc_pkg::*;

  logic [SampleW-1:0] start_low_q, start_high_q, lap_low_q, lap_high_q;
  logic               in_start, in_lap;

  // window registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_low_q  <= StartLowRst;
      start_high_q <= StartHighRst;
      lap_low_q    <= LapLowRst;
      lap_high_q   <= LapHighRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_START_LOW:  start_low_q  <= cfg_data_i;
        REG_START_HIGH: start_high_q <= cfg_data_i;
        REG_LAP_LOW:    lap_low_q    <= cfg_data_i;
        REG_LAP_HIGH:   lap_high_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // inclusive window match, start window has priority
  assign in_start      = (sample_i >= start_low_q) && (sample_i <= start_high_q);
  assign in_lap        = (sample_i >= lap_low_q) && (sample_i <= lap_high_q);
  assign press_o.start = in_start;
  assign press_o.lap   = in_lap && !in_start;

endmodule

// ----- hw/rtl/swlc_core.sv -----
module swlc_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  swlc_pkg::op_e     opcode_i,
  input  swlc_pkg::press_t  press_i,
  output swlc_pkg::shown_t  shown_d_o
);
  import swlc_pkg::*;

  mode_e              mode_q, mode_d;
  logic [TensW-1:0]   tens_q, tens_d;
  logic [DigitW-1:0]  ones_q, ones_d;
  logic [DigitW-1:0]  tenths_q, tenths_d;
  logic [TensW-1:0]   disp_tens_q, disp_tens_d;
  logic [DigitW-1:0]  disp_ones_q, disp_ones_d;
  logic [DigitW-1:0]  disp_tenths_q, disp_tenths_d;
  logic               holdoff_q, holdoff_d;

  logic [DigitW:0]    tenths_inc, ones_inc;
  logic [TensW:0]     tens_inc;
  logic               tenths_carry, ones_carry;
  logic [TensW-1:0]   cnt_tens;
  logic [DigitW-1:0]  cnt_ones, cnt_tenths;
  logic               pressed;

  // decimal increment with wrap at 59.9
  always_comb begin
    tenths_inc   = {1'b0, tenths_q} + 5'd1;
    tenths_carry = (tenths_inc >= TenthsLimit);
    cnt_tenths   = tenths_carry ? '0 : tenths_inc[DigitW-1:0];
    ones_inc     = {1'b0, ones_q} + {{DigitW{1'b0}}, tenths_carry};
    ones_carry   = (ones_inc >= OnesLimit);
    cnt_ones     = ones_carry ? '0 : ones_inc[DigitW-1:0];
    tens_inc     = {1'b0, tens_q} + {{TensW{1'b0}}, ones_carry};
    cnt_tens     = (tens_inc >= TensLimit) ? '0 : tens_inc[TensW-1:0];
  end

  assign pressed = press_i.start || press_i.lap;

  // next state for one item
  always_comb begin
    mode_d        = mode_q;
    tens_d        = tens_q;
    ones_d        = ones_q;
    tenths_d      = tenths_q;
    disp_tens_d   = disp_tens_q;
    disp_ones_d   = disp_ones_q;
    disp_tenths_d = disp_tenths_q;
    holdoff_d     = holdoff_q;
    if (opcode_i == OP_TICK) begin
      holdoff_d = 1'b0;
      if (mode_q == MODE_RUNNING || mode_q == MODE_LAPPED) begin
        tens_d   = cnt_tens;
        ones_d   = cnt_ones;
        tenths_d = cnt_tenths;
      end
      if (mode_q == MODE_RUNNING) begin
        disp_tens_d   = cnt_tens;
        disp_ones_d   = cnt_ones;
        disp_tenths_d = cnt_tenths;
      end
    end else if (!holdoff_q) begin
      unique case (mode_q)
        MODE_STOPPED: begin
          if (press_i.start) begin
            mode_d = MODE_RUNNING;
          end else if (press_i.lap) begin
            tens_d        = '0;
            ones_d        = '0;
            tenths_d      = '0;
            disp_tens_d   = '0;
            disp_ones_d   = '0;
            disp_tenths_d = '0;
          end
        end
        MODE_RUNNING: begin
          disp_tens_d   = tens_q;
          disp_ones_d   = ones_q;
          disp_tenths_d = tenths_q;
          if (press_i.start) begin
            mode_d = MODE_STOPPED;
          end else if (press_i.lap) begin
            mode_d = MODE_LAPPED;
          end
        end
        MODE_LAPPED: begin
          if (pressed) begin
            mode_d = MODE_RUNNING;
          end
        end
        default: ;
      endcase
      if (pressed) begin
        holdoff_d = 1'b1;
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_STOPPED;
      tens_q        <= '0;
      ones_q        <= '0;
      tenths_q      <= '0;
      disp_tens_q   <= '0;
      disp_ones_q   <= '0;
      disp_tenths_q <= '0;
      holdoff_q     <= 1'b0;
    end else if (fire_i) begin
      mode_q        <= mode_d;
      tens_q        <= tens_d;
      ones_q        <= ones_d;
      tenths_q      <= tenths_d;
      disp_tens_q   <= disp_tens_d;
      disp_ones_q   <= disp_ones_d;
      disp_tenths_q <= disp_tenths_d;
      holdoff_q     <= holdoff_d;
    end
  end

  assign shown_d_o.tens   = disp_tens_d;
  assign shown_d_o.ones   = disp_ones_d;
  assign shown_d_o.tenths = disp_tenths_d;
  assign shown_d_o.mode   = mode_d;

endmodule

// ----- hw/rtl/stopwatch_with_lap_control_unit.sv -----
// Stopwatch with lap hold: each request is a tenth-second tick (opcode 1) or a
// button-ladder converter reading (opcode 0) that the start and lap windows
// classify; every request yields one result holding the shown time (tens,
// ones, tenths of seconds, wrapping at 59.9) and the mode after it. A request
// is taken into an input register, processed from there and placed in the
// result register, so one request per cycle is sustained while the output
// does not stall; the input side stalls only while both the input and result
// registers hold work that the output has not taken.
// Window registers are written through the configuration port, which is always
// ready; writes are meant to happen while no request is in flight.
module stopwatch_with_lap_control_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [swlc_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [swlc_pkg::SampleW-1:0]         cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 opcode_i,
  input  logic [swlc_pkg::SampleW-1:0]         sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [swlc_pkg::TensW-1:0]           shown_tens_o,
  output logic [swlc_pkg::DigitW-1:0]          shown_ones_o,
  output logic [swlc_pkg::DigitW-1:0]          shown_tenths_o,
  output logic [1:0]                           mode_o
);
  import swlc_pkg::*;

  logic               req_valid_q;
  op_e                req_op_q;
  logic [SampleW-1:0] req_sample_q;
  logic               res_valid_q;
  shown_t             res_q;
  shown_t             shown_d;
  press_t             press;
  logic               res_free, fire, cfg_we;

  // pipeline handshake
  assign res_free    = !res_valid_q || !out_stall_i;
  assign fire        = req_valid_q && res_free;
  assign in_stall_o  = req_valid_q && !res_free;
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      req_op_q     <= op_e'(opcode_i);
      req_sample_q <= sample_i;
    end
  end

  swlc_classify u_classify (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .sample_i    (req_sample_q),
    .press_o     (press)
  );

  swlc_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .opcode_i  (req_op_q),
    .press_i   (press),
    .shown_d_o (shown_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_free) begin
      res_valid_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= shown_d;
    end
  end

  assign out_valid_o    = res_valid_q;
  assign shown_tens_o   = res_q.tens;
  assign shown_ones_o   = res_q.ones;
  assign shown_tenths_o = res_q.tenths;
  assign mode_o         = res_q.mode;

endmodule

// ----- sim/stopwatch_with_lap_control_unit_tb.sv -----
`timescale 1ns / 100ps

module stopwatch_with_lap_control_unit_tb;
  import swlc_pkg::*;

  localparam int NumRows = 41;
  localparam logic [CfgIdxW-1:0] UnusedIdx = 3'd7;
  localparam int IdleByPhase [4] = '{0, 64, 0, 19};
  localparam int StallByPhase [4] = '{0, 0, 64, 19};
  localparam int MaxPrinted = 50;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  // one step of the directed sequence: a request or a window write
  typedef struct packed {
    row_kind_e          kind;
    op_e                op;
    logic [CfgIdxW-1:0] idx;
    logic [SampleW-1:0] val;
    logic               typed;
    shown_t             want;
  } row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [SampleW-1:0] cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               opcode_i = 1'b0;
  logic [SampleW-1:0] sample_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [TensW-1:0]   shown_tens_o;
  logic [DigitW-1:0]  shown_ones_o;
  logic [DigitW-1:0]  shown_tenths_o;
  logic [1:0]         mode_o;

  // predictor copy of windows and stopwatch state
  logic [SampleW-1:0] win_start_lo = StartLowRst;
  logic [SampleW-1:0] win_start_hi = StartHighRst;
  logic [SampleW-1:0] win_lap_lo = LapLowRst;
  logic [SampleW-1:0] win_lap_hi = LapHighRst;
  mode_e              sw_mode = MODE_STOPPED;
  logic [TensW-1:0]   cnt_tens = '0;
  logic [DigitW-1:0]  cnt_ones = '0;
  logic [DigitW-1:0]  cnt_tenths = '0;
  logic [TensW-1:0]   disp_tens = '0;
  logic [DigitW-1:0]  disp_ones = '0;
  logic [DigitW-1:0]  disp_tenths = '0;
  logic               press_hold = 1'b0;

  shown_t pending_shown[$];
  int     n_mismatch = 0;
  int     idle_pct = 0;
  int     stall_pct = 0;
  row_t   dir_rows [NumRows];

  stopwatch_with_lap_control_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .sample_i       (sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .shown_tens_o   (shown_tens_o),
    .shown_ones_o   (shown_ones_o),
    .shown_tenths_o (shown_tenths_o),
    .mode_o         (mode_o)
  );

  always #10 clk_i = ~clk_i;

  // display follows the running count
  function automatic void show_count();
    disp_tens = cnt_tens;
    disp_ones = cnt_ones;
    disp_tenths = cnt_tenths;
  endfunction

  // advance the stopwatch by one request and return what it should show
  function automatic shown_t next_shown(op_e op, logic [SampleW-1:0] smp);
    logic hit_start;
    logic hit_lap;
    hit_start = (smp >= win_start_lo) && (smp <= win_start_hi);
    hit_lap = !hit_start && (smp >= win_lap_lo) && (smp <= win_lap_hi);
    if (op == OP_TICK) begin
      press_hold = 1'b0;
      if (sw_mode == MODE_RUNNING || sw_mode == MODE_LAPPED) begin
        cnt_tenths = cnt_tenths + 1'b1;
        if ({1'b0, cnt_tenths} >= TenthsLimit) begin
          cnt_tenths = '0;
          cnt_ones = cnt_ones + 1'b1;
        end
        if ({1'b0, cnt_ones} >= OnesLimit) begin
          cnt_ones = '0;
          cnt_tens = cnt_tens + 1'b1;
        end
        if ({1'b0, cnt_tens} >= TensLimit) cnt_tens = '0;
      end
      if (sw_mode == MODE_RUNNING) show_count();
    end else if (!press_hold) begin
      case (sw_mode)
        MODE_STOPPED: begin
          if (hit_start) begin
            sw_mode = MODE_RUNNING;
          end else if (hit_lap) begin
            cnt_tens = '0;
            cnt_ones = '0;
            cnt_tenths = '0;
            show_count();
          end
        end
        MODE_RUNNING: begin
          show_count();
          if (hit_start) sw_mode = MODE_STOPPED;
          else if (hit_lap) sw_mode = MODE_LAPPED;
        end
        default: begin
          if (hit_start || hit_lap) sw_mode = MODE_RUNNING;
        end
      endcase
      if (hit_start || hit_lap) press_hold = 1'b1;
    end
    return '{disp_tens, disp_ones, disp_tenths, sw_mode};
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (n_mismatch < MaxPrinted)
      $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    n_mismatch++;
  endtask

  // send one request, with random idle cycles ahead of it
  task automatic send_request(op_e op, logic [SampleW-1:0] smp, logic typed,
                              shown_t want);
    shown_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    sample_i <= smp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = next_shown(op, smp);
    pending_shown.push_back(typed ? want : predicted);
  endtask

  // stop sending and let every result come back
  task automatic drain_requests();
    in_valid_i <= 1'b0;
    while (pending_shown.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [SampleW-1:0] data);
    drain_requests();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_START_LOW:  win_start_lo = data;
      REG_START_HIGH: win_start_hi = data;
      REG_LAP_LOW:    win_lap_lo = data;
      REG_LAP_HIGH:   win_lap_hi = data;
      default: ;
    endcase
  endtask

  // random result-side stall
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // compare each taken result with the oldest pending one
  always @(posedge clk_i) begin
    shown_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_shown.size() == 0) begin
        report_mismatch("result with nothing pending", 0, 0);
      end else begin
        want = pending_shown.pop_front();
        if (shown_tens_o !== want.tens)
          report_mismatch("shown_tens", shown_tens_o, want.tens);
        if (shown_ones_o !== want.ones)
          report_mismatch("shown_ones", shown_ones_o, want.ones);
        if (shown_tenths_o !== want.tenths)
          report_mismatch("shown_tenths", shown_tenths_o, want.tenths);
        if (mode_o !== want.mode)
          report_mismatch("mode", mode_o, want.mode);
      end
    end
  end

  initial begin
    int unsigned  pick;
    int unsigned  taken;
    int unsigned  s_lo, s_hi, l_lo, l_hi;
    logic [SampleW-1:0] smp;
    op_e          op;

    // directed sequence: reset state, extremes, every mode change,
    // overlapping windows, inverted windows, unused register index
    dir_rows = '{
      '{ROW_ITEM, OP_SAMPLE, 3'd0, 8'd0,   1'b1, '{3'd0, 4'd0, 4'd0, MODE_STOPPED}},
      '{ROW_ITEM, OP_SAMPLE, 3'd0, 8'd255, 1'b1, '{3'd0, 4'd0, 4'd0, MODE_STOPPED}},
      '{ROW_ITEM, OP_TICK,   3'd0, 8'd255, 1'b1, '{3'd0, 4'd0, 4'd0, MODE_STOPPED}},
      '{ROW_ITEM, OP_SAMPLE, 3'd0, 8'd50,  1'b1, '{3'd0, 4'd0, 4'd0, MODE_RUNNING}},
      '{ROW_ITEM, OP_SAMPLE, 3'd0, 8'd60,  1'b1, '{3'd0, 4'd0, 4'd0, MODE_RUNNING}},
      '{ROW_ITEM, OP_TICK,   3'd0, 8'd0,   1'b0, '0},
      '{ROW_ITEM, OP_SAMPLE, 3'd0, 8'd110, 1'b0, '0},
      '{ROW_ITEM, OP_TICK,   3'd0, 8'd0,   1'b0, '0},
      '{ROW_ITEM, OP_SAMPLE, 3'd0, 8'd100, 1'b0, '0},
      '{ROW_ITEM, OP_TICK,   3'd0, 8'd0,   1'b0, '0},
      '{ROW_ITEM, OP_SAMPLE, 3'd0, 8'd49,  1'b0, '0},
      '{ROW_ITEM, OP_SAMPLE, 3'd0, 8'd111, 1'b0, '0},
      '{ROW_ITEM, OP_SAMPLE, 3'd0, 8'd105, 1'b0, '0},
      '{ROW_ITEM, OP_TICK,   3'd0, 8'd0,   1'b0, '0},
      '{ROW_ITEM, OP_SAMPLE, 3'd0, 8'd55,  1'b0, '0},
      '{ROW_ITEM, OP_TICK,   3'd0, 8'd0,   1'b0, '0},
      '{ROW_ITEM, OP_SAMPLE, 3'd0, 8'd60,  1'b0, '0},
      '{ROW_ITEM, OP_TICK,   3'd0, 8'd0,   1'b0, '0},
      '{ROW_ITEM, OP_SAMPLE, 3'd0, 8'd101, 1'b1, '{3'd0, 4'd0, 4'd0, MODE_STOPPED}},
      '{ROW_ITEM, OP_TICK,   3'd0, 8'd0,   1'b1, '{3'd0, 4'd0, 4'd0, MODE_STOPPED}},
      '{ROW_CFG,  OP_SAMPLE, REG_START_LOW,  8'd0,   1'b0, '0},
      '{ROW_CFG,  OP_SAMPLE, REG_START_HIGH, 8'd255, 1'b0, '0},
      '{ROW_CFG,  OP_SAMPLE, REG_LAP_LOW,    8'd0,   1'b0, '0},
      '{ROW_CFG,  OP_SAMPLE, REG_LAP_HIGH,   8'd255, 1'b0, '0},
      '{ROW_ITEM, OP_SAMPLE, 3'd0, 8'd128, 1'b1, '{3'd0, 4'd0, 4'd0, MODE_RUNNING}},
      '{ROW_ITEM, OP_TICK,   3'd0, 8'd0,   1'b0, '0},
      '{ROW_ITEM, OP_SAMPLE, 3'd0, 8'd0,   1'b0, '0},
      '{ROW_CFG,  OP_SAMPLE, REG_START_LOW,  8'd255, 1'b0, '0},
      '{ROW_CFG,  OP_SAMPLE, REG_START_HIGH, 8'd0,   1'b0, '0},
      '{ROW_CFG,  OP_SAMPLE, REG_LAP_LOW,    8'd200, 1'b0, '0},
      '{ROW_CFG,  OP_SAMPLE, REG_LAP_HIGH,   8'd100, 1'b0, '0},
      '{ROW_ITEM, OP_TICK,   3'd0, 8'd0,   1'b0, '0},
      '{ROW_ITEM, OP_SAMPLE, 3'd0, 8'd0,   1'b0, '0},
      '{ROW_ITEM, OP_SAMPLE, 3'd0, 8'd255, 1'b0, '0},
      '{ROW_CFG,  OP_SAMPLE, UnusedIdx,      8'hA5,  1'b0, '0},
      '{ROW_CFG,  OP_SAMPLE, REG_LAP_HIGH,   8'd255, 1'b0, '0},
      '{ROW_ITEM, OP_SAMPLE, 3'd0, 8'd255, 1'b1, '{3'd0, 4'd0, 4'd0, MODE_STOPPED}},
      '{ROW_CFG,  OP_SAMPLE, REG_START_LOW,  StartLowRst,  1'b0, '0},
      '{ROW_CFG,  OP_SAMPLE, REG_START_HIGH, StartHighRst, 1'b0, '0},
      '{ROW_CFG,  OP_SAMPLE, REG_LAP_LOW,    LapLowRst,    1'b0, '0},
      '{ROW_CFG,  OP_SAMPLE, REG_LAP_HIGH,   LapHighRst,   1'b0, '0}
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = 19;
    stall_pct = 19;
    for (int r = 0; r < NumRows; r++) begin
      if (dir_rows[r].kind == ROW_CFG)
        write_cfg(dir_rows[r].idx, dir_rows[r].val);
      else
        send_request(dir_rows[r].op, dir_rows[r].val, dir_rows[r].typed,
                     dir_rows[r].want);
    end

    // twelve seconds of ticks while running, through the tenths and ones carries;
    // a tick first clears the holdoff left by the last lap press
    idle_pct = 0;
    stall_pct = 0;
    send_request(OP_TICK, 8'd0, 1'b0, '0);
    send_request(OP_SAMPLE, StartLowRst, 1'b0, '0);
    repeat (120) send_request(OP_TICK, 8'($urandom), 1'b0, '0);
    send_request(OP_SAMPLE, StartHighRst, 1'b0, '0);

    // random phases, each with its own windows and its own mix of idle and stall rates
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = IdleByPhase[ph];
      stall_pct = StallByPhase[ph];
      case (ph)
        0: begin
          s_lo = 0;   s_hi = 20;  l_lo = 235; l_hi = 255;
        end
        2: begin
          s_lo = 128; s_hi = 255; l_lo = 0;   l_hi = 127;
        end
        1: begin
          s_lo = $urandom_range(255);
          s_hi = $urandom_range(255, s_lo);
          l_lo = $urandom_range(255);
          l_hi = $urandom_range(255, l_lo);
        end
        default: begin
          s_lo = $urandom_range(255);
          s_hi = $urandom_range(255);
          l_lo = $urandom_range(255);
          l_hi = $urandom_range(255);
        end
      endcase
      write_cfg(REG_START_LOW, 8'(s_lo));
      write_cfg(REG_START_HIGH, 8'(s_hi));
      write_cfg(REG_LAP_LOW, 8'(l_lo));
      write_cfg(REG_LAP_HIGH, 8'(l_hi));

      // mostly ticks and presses inside the windows, some noise
      taken = 0;
      while (taken < 50) begin
        pick = $urandom_range(99);
        smp = 8'($urandom);
        op = OP_SAMPLE;
        if (pick < 40)
          op = OP_TICK;
        else if (pick < 65 && win_start_lo <= win_start_hi)
          smp = 8'($urandom_range(win_start_hi, win_start_lo));
        else if (pick >= 65 && pick < 85 && win_lap_lo <= win_lap_hi)
          smp = 8'($urandom_range(win_lap_hi, win_lap_lo));
        if (op == OP_TICK || !press_hold) taken++;
        send_request(op, smp, 1'b0, '0);
      end
    end

    drain_requests();
    if (n_mismatch == 0) begin
      $display("stopwatch_with_lap_control_unit_tb: PASS");
    end else begin
      $display("stopwatch_with_lap_control_unit_tb: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(5_000_000);
    $display("stopwatch_with_lap_control_unit_tb: FAIL");
    $finish;
  end

endmodule
